### rtl/seconds_to_calendar_date_defines.svh
// Assertion macros used by the seconds-to-calendar-date RTL.
`ifndef SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define STCD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define STCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stcd_pkg.sv
// Types, constants, microcode ROM and calendar tables for the date converter.
`default_nettype none

package stcd_pkg;

    // Field widths
    localparam int SECS_W  = 32;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    // Datapath widths
    localparam int DAYS_W  = 16;
    localparam int QUO_W   = 16;
    localparam int YDAYS_W = 9;
    localparam int NUM_W   = 25;
    localparam int RCP_W   = 26;
    localparam int PROD_W  = NUM_W + RCP_W;
    localparam int DIVF_W  = 17;

    // Calendar constants
    localparam logic [YEAR_W-1:0]  FIRST_YEAR       = 12'd1970;
    localparam logic [YDAYS_W-1:0] COMMON_YEAR_DAYS = 9'd365;
    localparam logic [YDAYS_W-1:0] LEAP_YEAR_DAYS   = 9'd366;
    localparam logic [MONTH_W-1:0] MONTH_JAN        = 4'd1;
    localparam logic [MONTH_W-1:0] MONTHS           = 4'd12;

    // Microcode layout
    localparam int OP_W   = 4;
    localparam int CSEL_W = 2;
    localparam int PC_W   = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WAIT  = 4'd0;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd1;
    localparam logic [OP_W-1:0] OP_REM   = 4'd2;
    localparam logic [OP_W-1:0] OP_FIX   = 4'd3;
    localparam logic [OP_W-1:0] OP_STDAY = 4'd4;
    localparam logic [OP_W-1:0] OP_STHR  = 4'd5;
    localparam logic [OP_W-1:0] OP_STMIN = 4'd6;
    localparam logic [OP_W-1:0] OP_YEAR  = 4'd7;
    localparam logic [OP_W-1:0] OP_MONTH = 4'd8;
    localparam logic [OP_W-1:0] OP_OUT   = 4'd9;

    // Divisor selects
    localparam logic [CSEL_W-1:0] SEL_DAY  = 2'd0;
    localparam logic [CSEL_W-1:0] SEL_HOUR = 2'd1;
    localparam logic [CSEL_W-1:0] SEL_MIN  = 2'd2;

    // Program steps
    localparam logic [PC_W-1:0] PC_WAIT = 4'd0;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CSEL_W-1:0] csel;
        logic [PC_W-1:0]   nxt;
    } t_uop;

    // Control program: one control word per step, nxt taken when the step completes
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '{op: OP_WAIT, csel: SEL_DAY, nxt: PC_WAIT};
        unique case (pc)
            4'd0:  u = '{op: OP_WAIT,  csel: SEL_DAY,  nxt: 4'd1};
            4'd1:  u = '{op: OP_MUL,   csel: SEL_DAY,  nxt: 4'd2};
            4'd2:  u = '{op: OP_REM,   csel: SEL_DAY,  nxt: 4'd3};
            4'd3:  u = '{op: OP_FIX,   csel: SEL_DAY,  nxt: 4'd4};
            4'd4:  u = '{op: OP_STDAY, csel: SEL_DAY,  nxt: 4'd5};
            4'd5:  u = '{op: OP_MUL,   csel: SEL_HOUR, nxt: 4'd6};
            4'd6:  u = '{op: OP_REM,   csel: SEL_HOUR, nxt: 4'd7};
            4'd7:  u = '{op: OP_FIX,   csel: SEL_HOUR, nxt: 4'd8};
            4'd8:  u = '{op: OP_STHR,  csel: SEL_HOUR, nxt: 4'd9};
            4'd9:  u = '{op: OP_MUL,   csel: SEL_MIN,  nxt: 4'd10};
            4'd10: u = '{op: OP_REM,   csel: SEL_MIN,  nxt: 4'd11};
            4'd11: u = '{op: OP_FIX,   csel: SEL_MIN,  nxt: 4'd12};
            4'd12: u = '{op: OP_STMIN, csel: SEL_MIN,  nxt: 4'd13};
            4'd13: u = '{op: OP_YEAR,  csel: SEL_DAY,  nxt: 4'd14};
            4'd14: u = '{op: OP_MONTH, csel: SEL_DAY,  nxt: 4'd15};
            4'd15: u = '{op: OP_OUT,   csel: SEL_DAY,  nxt: PC_WAIT};
        endcase
        return u;
    endfunction

    // Dividend with the divisor's power of two shifted out:
    // 86400 = 675 << 7, 3600 = 225 << 4, 60 = 15 << 2
    function automatic logic [NUM_W-1:0] div_num(input logic [CSEL_W-1:0] csel,
                                                 input logic [SECS_W-1:0] acc);
        logic [NUM_W-1:0] n;
        n = acc[SECS_W-1:7];
        unique case (csel)
            SEL_DAY:  n = acc[SECS_W-1:7];
            SEL_HOUR: n = {12'd0, acc[16:4]};
            SEL_MIN:  n = {15'd0, acc[11:2]};
            default:  n = acc[SECS_W-1:7];
        endcase
        return n;
    endfunction

    // Reciprocal of the odd part, rounded down: 2^35/675, 2^21/225, 2^16/15
    function automatic logic [RCP_W-1:0] div_recip(input logic [CSEL_W-1:0] csel);
        logic [RCP_W-1:0] r;
        r = 26'd50903316;
        unique case (csel)
            SEL_DAY:  r = 26'd50903316;
            SEL_HOUR: r = 26'd9320;
            SEL_MIN:  r = 26'd4369;
            default:  r = 26'd50903316;
        endcase
        return r;
    endfunction

    // Quotient estimate from the product; it is the true quotient or one less
    function automatic logic [QUO_W-1:0] div_quo(input logic [CSEL_W-1:0] csel,
                                                 input logic [PROD_W-1:0] prod);
        logic [QUO_W-1:0] q;
        q = prod[50:35];
        unique case (csel)
            SEL_DAY:  q = prod[50:35];
            SEL_HOUR: q = {11'd0, prod[25:21]};
            SEL_MIN:  q = {10'd0, prod[21:16]};
            default:  q = prod[50:35];
        endcase
        return q;
    endfunction

    // Full divisor for each division
    function automatic logic [DIVF_W-1:0] div_full(input logic [CSEL_W-1:0] csel);
        logic [DIVF_W-1:0] d;
        d = 17'd86400;
        unique case (csel)
            SEL_DAY:  d = 17'd86400;
            SEL_HOUR: d = 17'd3600;
            SEL_MIN:  d = 17'd60;
            default:  d = 17'd86400;
        endcase
        return d;
    endfunction

    // Days in a month, 1 is January
    function automatic logic [DAY_W-1:0] month_length(input logic leap,
                                                      input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] d;
        d = 5'd31;
        unique case (month)
            4'd2:    d = leap ? 5'd29 : 5'd28;
            4'd4:    d = 5'd30;
            4'd6:    d = 5'd30;
            4'd9:    d = 5'd30;
            4'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/seconds_to_calendar_date.sv
// Top level of the seconds-to-calendar-date converter, a microcoded sequencer.
`default_nettype none

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into year, month,
// day, hour, minute and second; every year divisible by four is a leap year, so
// 2100 is one. One transaction is worked at a time by a 16-step microprogram.
// Each division by 86400, 3600 and 60 runs a reciprocal multiply for a quotient
// estimate, a remainder subtract and one correction, then a store step; then a
// year walk takes off whole years and a month walk takes off whole months.
// While the output register stays full the program holds at its output step.
// The next transaction is taken in the cycle after the result is loaded, while
// the result still waits.
module seconds_to_calendar_date (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire [stcd_pkg::SECS_W-1:0]   i_epoch_seconds,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [stcd_pkg::YEAR_W-1:0]  o_year,
    output logic [stcd_pkg::MONTH_W-1:0] o_month,
    output logic [stcd_pkg::DAY_W-1:0]   o_day,
    output logic [stcd_pkg::HOUR_W-1:0]  o_hour,
    output logic [stcd_pkg::MIN_W-1:0]   o_minute,
    output logic [stcd_pkg::SEC_W-1:0]   o_second
);
    import stcd_pkg::*;

    `include "seconds_to_calendar_date_defines.svh"

    // Sequencer and datapath registers
    logic [PC_W-1:0]    r_pc,      n_pc;
    logic [SECS_W-1:0]  r_acc,     n_acc;
    logic [QUO_W-1:0]   r_quo,     n_quo;
    logic [DAYS_W-1:0]  r_days,    n_days;
    logic [YEAR_W-1:0]  r_year,    n_year;
    logic [MONTH_W-1:0] r_month,   n_month;
    logic [HOUR_W-1:0]  r_hour,    n_hour;
    logic [MIN_W-1:0]   r_minute,  n_minute;
    logic [SEC_W-1:0]   r_second,  n_second;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic [YEAR_W-1:0]  r_o_year,    n_o_year;
    logic [MONTH_W-1:0] r_o_month,   n_o_month;
    logic [DAY_W-1:0]   r_o_day,     n_o_day;
    logic [HOUR_W-1:0]  r_o_hour,    n_o_hour;
    logic [MIN_W-1:0]   r_o_minute,  n_o_minute;
    logic [SEC_W-1:0]   r_o_second,  n_o_second;

    t_uop                    uop;
    logic [PROD_W-1:0]       prod;
    logic [QUO_W+DIVF_W-1:0] rem_prod;
    logic [SECS_W-1:0]       dfull;
    logic                    fix_ge;
    logic                    leap;
    logic [YDAYS_W-1:0]      ydays;
    logic [DAY_W-1:0]        mdays;
    logic                    adv;

    // Decode the current step
    assign uop      = uop_rom(r_pc);
    assign prod     = div_num(uop.csel, r_acc) * div_recip(uop.csel);
    assign rem_prod = r_quo * div_full(uop.csel);
    assign dfull    = {{(SECS_W-DIVF_W){1'b0}}, div_full(uop.csel)};
    assign fix_ge   = (r_acc >= dfull);
    assign leap     = (r_year[1:0] == 2'b00);
    assign ydays    = leap ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS;
    assign mdays    = month_length(leap, r_month);

    // Execute the control word and pick the next step
    always_comb begin
        n_pc        = r_pc;
        n_acc       = r_acc;
        n_quo       = r_quo;
        n_days      = r_days;
        n_year      = r_year;
        n_month     = r_month;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_second    = r_second;
        n_out_valid = r_out_valid & i_out_stall;
        n_o_year    = r_o_year;
        n_o_month   = r_o_month;
        n_o_day     = r_o_day;
        n_o_hour    = r_o_hour;
        n_o_minute  = r_o_minute;
        n_o_second  = r_o_second;
        adv         = 1'b0;

        unique case (uop.op)
            OP_WAIT: begin
                if (i_in_valid) begin
                    n_acc = i_epoch_seconds;
                    adv   = 1'b1;
                end
            end
            OP_MUL: begin
                // Estimate the quotient by the reciprocal of the odd part
                n_quo = div_quo(uop.csel, prod);
                adv   = 1'b1;
            end
            OP_REM: begin
                // Take the estimate times the divisor off the dividend
                n_acc = r_acc - rem_prod[SECS_W-1:0];
                adv   = 1'b1;
            end
            OP_FIX: begin
                // Bump the quotient once when the remainder still holds a divisor
                if (fix_ge) begin
                    n_acc = r_acc - dfull;
                    n_quo = r_quo + 1'b1;
                end
                adv = 1'b1;
            end
            OP_STDAY: begin
                n_days  = r_quo + 1'b1;
                n_year  = FIRST_YEAR;
                n_month = MONTH_JAN;
                adv     = 1'b1;
            end
            OP_STHR: begin
                n_hour = r_quo[HOUR_W-1:0];
                adv    = 1'b1;
            end
            OP_STMIN: begin
                n_minute = r_quo[MIN_W-1:0];
                n_second = r_acc[SEC_W-1:0];
                adv      = 1'b1;
            end
            OP_YEAR: begin
                // Take off whole years until the rest fits in the current one
                if (r_days > {{(DAYS_W-YDAYS_W){1'b0}}, ydays}) begin
                    n_days = r_days - {{(DAYS_W-YDAYS_W){1'b0}}, ydays};
                    n_year = r_year + 1'b1;
                end else begin
                    adv = 1'b1;
                end
            end
            OP_MONTH: begin
                // Take off whole months; December holds whatever is left
                if ((r_days <= {{(DAYS_W-DAY_W){1'b0}}, mdays}) || (r_month == MONTHS)) begin
                    adv = 1'b1;
                end else begin
                    n_days  = r_days - {{(DAYS_W-DAY_W){1'b0}}, mdays};
                    n_month = r_month + 1'b1;
                end
            end
            OP_OUT: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_year    = r_year;
                    n_o_month   = r_month;
                    n_o_day     = r_days[DAY_W-1:0];
                    n_o_hour    = r_hour;
                    n_o_minute  = r_minute;
                    n_o_second  = r_second;
                    adv         = 1'b1;
                end
            end
            default: begin
                n_pc = PC_WAIT;
            end
        endcase

        if (adv) begin
            n_pc = uop.nxt;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_quo      <= n_quo;
        r_days     <= n_days;
        r_year     <= n_year;
        r_month    <= n_month;
        r_hour     <= n_hour;
        r_minute   <= n_minute;
        r_second   <= n_second;
        r_o_year   <= n_o_year;
        r_o_month  <= n_o_month;
        r_o_day    <= n_o_day;
        r_o_hour   <= n_o_hour;
        r_o_minute <= n_o_minute;
        r_o_second <= n_o_second;
    end

    // Drive ports
    assign o_in_stall  = (uop.op != OP_WAIT);
    assign o_out_valid = r_out_valid;
    assign o_year      = r_o_year;
    assign o_month     = r_o_month;
    assign o_day       = r_o_day;
    assign o_hour      = r_o_hour;
    assign o_minute    = r_o_minute;
    assign o_second    = r_o_second;

    // The estimate is never too large, so one correction brings the remainder in range
    `STCD_ASSERT_NOW(a_div_bound, i_clk, i_rst_n, uop.op == OP_FIX,
                     ({1'b0, r_acc} < {dfull, 1'b0}), "division remainder out of range")
    // An accepted transaction starts the day division next
    `STCD_ASSERT_NEXT(a_accept_start, i_clk, i_rst_n, i_in_valid && !o_in_stall,
                      uop.op == OP_MUL, "accept did not start the program")
    // Month walk stays within the year and never runs out of days
    `STCD_ASSERT_NOW(a_month_walk, i_clk, i_rst_n, uop.op == OP_MONTH,
                     (r_month >= MONTH_JAN) && (r_month <= MONTHS) && (r_days != '0),
                     "month walk out of range")
    // A delivered result holds a legal time of day and day of month
    `STCD_ASSERT_NOW(a_out_range, i_clk, i_rst_n, o_out_valid,
                     (o_hour < 5'd24) && (o_minute < 6'd60) && (o_second < 6'd60) && (o_day != '0),
                     "result field out of range")

endmodule

`default_nettype wire

### bench/tb_seconds_to_calendar_date.sv
// Self-checking testbench for the seconds-to-calendar-date converter.
`timescale 1ns / 1ps

module tb_seconds_to_calendar_date;

    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned EPOCH_YEAR    = 1970;
    localparam int unsigned LEAP_MASK     = 3;
    localparam int unsigned LAST_MONTH    = 12;
    localparam int unsigned FEBRUARY      = 2;

    localparam int RANDOM_ITEMS  = 1800;
    localparam int MODE_SPAN     = 600;
    localparam int DRAIN_AT      = 700;
    localparam int HOLD_AT       = 250;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 200;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PRINT_LIMIT   = 100;

    typedef enum logic [1:0] {
        MODE_SLOW_RX,
        MODE_SLOW_TX,
        MODE_FULL_RATE
    } t_idle_mode;

    typedef struct packed {
        logic [stcd_pkg::YEAR_W-1:0]  year;
        logic [stcd_pkg::MONTH_W-1:0] month;
        logic [stcd_pkg::DAY_W-1:0]   day;
        logic [stcd_pkg::HOUR_W-1:0]  hour;
        logic [stcd_pkg::MIN_W-1:0]   minute;
        logic [stcd_pkg::SEC_W-1:0]   second;
    } t_cal_date;

    typedef struct {
        logic [stcd_pkg::SECS_W-1:0] secs;
        t_idle_mode                  mode;
        bit                          wait_for_empty;
    } t_send_item;

    typedef struct {
        logic [stcd_pkg::SECS_W-1:0] secs;
        t_cal_date                   date;
    } t_date_expect;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [stcd_pkg::SECS_W-1:0]   i_epoch_seconds = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [stcd_pkg::YEAR_W-1:0]   o_year;
    logic [stcd_pkg::MONTH_W-1:0]  o_month;
    logic [stcd_pkg::DAY_W-1:0]    o_day;
    logic [stcd_pkg::HOUR_W-1:0]   o_hour;
    logic [stcd_pkg::MIN_W-1:0]    o_minute;
    logic [stcd_pkg::SEC_W-1:0]    o_second;

    t_send_item   secs_to_send [$];
    t_date_expect expected_dates [$];
    t_send_item   next_send;
    t_date_expect taken_date;
    t_date_expect oldest_date;
    t_idle_mode   cur_mode = MODE_SLOW_RX;

    int  items_queued = 0;
    int  taken_count = 0;
    int  results_seen = 0;
    int  error_count = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  quiet_cycles = 0;
    int  pick;
    bit  in_taken;
    bit  out_taken;

    seconds_to_calendar_date i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_epoch_seconds (i_epoch_seconds),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

    // Generate the 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned month_size(input int unsigned yr,
                                               input int unsigned mon);
        int unsigned len;
        len = 31;
        if (mon == FEBRUARY) begin
            len = ((yr & LEAP_MASK) == 0) ? 29 : 28;
        end else if (mon == 4 || mon == 6 || mon == 9 || mon == 11) begin
            len = 30;
        end
        return len;
    endfunction

    // Every year divisible by four is a leap year here, 2100 included
    function automatic t_cal_date calendar_of_seconds(input logic [stcd_pkg::SECS_W-1:0] secs);
        int unsigned days;
        int unsigned rem;
        int unsigned hr;
        int unsigned mn;
        int unsigned sc;
        int unsigned yr;
        int unsigned year_len;
        int unsigned mon;
        t_cal_date   d;
        days = secs / SECS_PER_DAY + 1;
        rem = secs % SECS_PER_DAY;
        hr = rem / SECS_PER_HOUR;
        rem = rem % SECS_PER_HOUR;
        mn = rem / SECS_PER_MIN;
        sc = rem % SECS_PER_MIN;
        // Walk whole years off the day count
        yr = EPOCH_YEAR;
        year_len = 365;
        while (days > year_len) begin
            days = days - year_len;
            yr = yr + 1;
            year_len = ((yr & LEAP_MASK) == 0) ? 366 : 365;
        end
        // Walk whole months off what is left
        mon = 1;
        while (mon < LAST_MONTH && days > month_size(yr, mon)) begin
            days = days - month_size(yr, mon);
            mon = mon + 1;
        end
        d.year = yr[stcd_pkg::YEAR_W-1:0];
        d.month = mon[stcd_pkg::MONTH_W-1:0];
        d.day = days[stcd_pkg::DAY_W-1:0];
        d.hour = hr[stcd_pkg::HOUR_W-1:0];
        d.minute = mn[stcd_pkg::MIN_W-1:0];
        d.second = sc[stcd_pkg::SEC_W-1:0];
        return d;
    endfunction

    function automatic int sender_idle_pct(input t_idle_mode mode);
        unique case (mode)
            MODE_SLOW_RX: return 38;
            MODE_SLOW_TX: return 61;
            default:      return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct(input t_idle_mode mode);
        unique case (mode)
            MODE_SLOW_RX: return 61;
            MODE_SLOW_TX: return 38;
            default:      return 0;
        endcase
    endfunction

    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("ERROR: %s", msg);
        end
        error_count = error_count + 1;
    endtask

    task automatic check_field(input logic [stcd_pkg::SECS_W-1:0] secs, input string name,
                               input int unsigned got, input int unsigned want);
        if (got != want) begin
            report_error($sformatf("seconds %0d: %s is %0d, expected %0d",
                                   secs, name, got, want));
        end
    endtask

    // Queue one transaction; the idle mode follows its position in the run
    task automatic add_item(input logic [stcd_pkg::SECS_W-1:0] secs);
        t_send_item it;
        it.secs = secs;
        if (items_queued < MODE_SPAN) begin
            it.mode = MODE_SLOW_RX;
        end else if (items_queued < 2 * MODE_SPAN) begin
            it.mode = MODE_SLOW_TX;
        end else begin
            it.mode = MODE_FULL_RATE;
        end
        it.wait_for_empty = (items_queued == DRAIN_AT);
        secs_to_send.push_back(it);
        items_queued = items_queued + 1;
    endtask

    // Driver: record accepted transactions, then hold, advance or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) begin
                taken_date.secs = i_epoch_seconds;
                taken_date.date = calendar_of_seconds(i_epoch_seconds);
                expected_dates.push_back(taken_date);
                taken_count <= taken_count + 1;
            end
            if (!i_in_valid || in_taken) begin
                if (secs_to_send.size() != 0
                    && $urandom_range(99) >= sender_idle_pct(secs_to_send[0].mode)
                    && !(secs_to_send[0].wait_for_empty
                         && taken_count + int'(in_taken) != results_seen)) begin
                    next_send = secs_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    i_epoch_seconds <= next_send.secs;
                    cur_mode <= next_send.mode;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off so the block fills and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && taken_count == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: compare each accepted result with the oldest expected date
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen <= results_seen + 1;
                if (expected_dates.size() == 0) begin
                    report_error($sformatf("result %0d-%0d-%0d %0d:%0d:%0d with none expected",
                                           o_year, o_month, o_day, o_hour, o_minute, o_second));
                end else begin
                    oldest_date = expected_dates.pop_front();
                    check_field(oldest_date.secs, "year", 32'(o_year),
                                32'(oldest_date.date.year));
                    check_field(oldest_date.secs, "month", 32'(o_month),
                                32'(oldest_date.date.month));
                    check_field(oldest_date.secs, "day", 32'(o_day),
                                32'(oldest_date.date.day));
                    check_field(oldest_date.secs, "hour", 32'(o_hour),
                                32'(oldest_date.date.hour));
                    check_field(oldest_date.secs, "minute", 32'(o_minute),
                                32'(oldest_date.date.minute));
                    check_field(oldest_date.secs, "second", 32'(o_second),
                                32'(oldest_date.date.second));
                end
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_idle_pct(cur_mode));
        end
    end

    // Watchdog: end the run after too long without any transaction
    always @(posedge i_clk) begin
        out_taken = o_out_valid && !i_out_stall;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || out_taken) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_seconds_to_calendar_date: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // Directed: field extremes, unit boundaries, leap days, the 2100 quirk
        add_item(32'd0);
        add_item(32'd1);
        add_item(32'd59);
        add_item(32'd60);
        add_item(32'd3599);
        add_item(32'd3600);
        add_item(32'd86399);
        add_item(32'd86400);
        add_item(32'd31535999);
        add_item(32'd31536000);
        add_item(32'd68169599);
        add_item(32'd68169600);
        add_item(32'd94694399);
        add_item(32'd94694400);
        add_item(32'd951868800);
        add_item(32'd4102444799);
        add_item(32'd4102444800);
        add_item(32'd4107542399);
        add_item(32'd4107542400);
        add_item(32'd4107628800);
        add_item(32'h7FFFFFFF);
        add_item(32'h80000000);
        add_item(32'h55555555);
        add_item(32'hAAAAAAAA);
        add_item(32'hFFFFFFFF);

        // Random: mostly full range, plus day edges, early dates and the final years
        repeat (RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                add_item($urandom());
            end else if (pick < 75) begin
                add_item($urandom_range(49709) * SECS_PER_DAY
                         + (($urandom_range(1) == 0) ? 0 : SECS_PER_DAY - 1));
            end else if (pick < 87) begin
                add_item($urandom_range(94694400));
            end else begin
                add_item(32'd4102444800 + $urandom_range(192522495));
            end
        end

        // Hold reset low, then release it
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: wait for the last transaction and result, then let the block settle
        @(negedge i_clk);
        while (secs_to_send.size() != 0 || i_in_valid || expected_dates.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("tb_seconds_to_calendar_date: clean");
        end else begin
            $display("tb_seconds_to_calendar_date: errors");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/stcd_pkg.sv
rtl/seconds_to_calendar_date.sv
bench/tb_seconds_to_calendar_date.sv
